### rtl/positional_list_engine_assert.svh
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every edge outside reset.
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int POS_W      = 7;
    localparam int ENTRY_W    = 32;
    localparam int LEN_W      = 7;
    localparam int OUT_DATA_W = 32;
    localparam int KIND_W     = 3;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int XW     = (DATA_WIDTH > ENTRY_W) ? DATA_WIDTH : ENTRY_W;

    localparam int S_TDATA_W = ((POS_W + ENTRY_W + 7) / 8) * 8;
    localparam int M_FIELD_W = 1 + OUT_DATA_W + LEN_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_READ    = 3'd2,
        KIND_REPLACE = 3'd3,
        KIND_CLEAR   = 3'd4,
        KIND_STATUS  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_FIN,
        S_RDATA,
        S_DONE
    } state_t;

    function automatic word_t to_word(input logic [ENTRY_W-1:0] e);
        logic [XW-1:0] t;
        t = XW'(e);
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_DATA_W-1:0] to_out(input word_t w);
        logic [XW-1:0] t;
        t = XW'(w);
        return t[OUT_DATA_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] to_len(input cnt_t c);
        cmp_t t;
        t = CMP_W'(c);
        return t[LEN_W-1:0];
    endfunction

endpackage

### rtl/positional_list_engine.sv
// Positional list engine: a bounded ordered list with 1-based positions.
// Input channel s_*: one command per transfer (insert, remove, read, replace,
// clear, status). Output channel m_*: exactly one result per command, in order.
// Entries live in a single-port-write, one-read synchronous RAM with registered read.
// Insert and remove move the tail of the list one entry per cycle through the
// RAM: a read is issued each cycle and the word read the cycle before is
// written one slot up or down. A move passes through S_MOVE, then S_FIN and
// S_DONE; the longest move, and so the slowest result, comes from an insert at
// position 1 into a list one short of full, or a remove at position 1 when full.
// Insert at the tail passes through S_FIN, read and replace through S_RDATA;
// removing the last entry, clear, status and failed commands go to S_DONE directly.
// One command is processed at a time; s_tready is high while the engine idles,
// including while a previous result still waits in the output register. The
// next transfer can be taken in the same cycle as a result turns valid.
// If the receiver stalls, the finished result holds in the engine until the
// output register frees up; no result is dropped.
// Reset empties the list (count 0) and drops any pending result. RAM contents
// are not cleared; slots beyond the count are never read.
module positional_list_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [6:0] position, [38:7] entry, [39] zero
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] kind
    input  logic [ple_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] ok, [32:1] data_out, [39:33] length, [40] empty_res, [47:41] zero
    output logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);

    ple_pkg::state_t state_reg, state_next;
    ple_pkg::cnt_t   count_reg, count_next;

    // move sequencer
    ple_pkg::addr_t  ra_reg, ra_next;     // next RAM read address
    ple_pkg::addr_t  end_reg, end_next;   // last read address of the move
    ple_pkg::addr_t  wa_reg, wa_next;     // target of the word read last cycle
    logic            issue_reg, issue_next;
    logic            pend_reg, pend_next;
    logic            up_reg, up_next;     // 1: entries move up (insert)
    ple_pkg::addr_t  fin_addr_reg, fin_addr_next;
    ple_pkg::word_t  val_reg, val_next;

    logic            res_ok_reg, res_ok_next;
    ple_pkg::word_t  res_data_reg, res_data_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [ple_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM port signals
    ple_pkg::word_t  mem [ple_pkg::CAPACITY];
    ple_pkg::word_t  rdata_reg;
    logic            mem_we, mem_re;
    ple_pkg::addr_t  mem_wa, mem_ra;
    ple_pkg::word_t  mem_wd;

    // command decode
    logic [ple_pkg::POS_W-1:0]   in_pos;
    logic [ple_pkg::ENTRY_W-1:0] in_entry;
    ple_pkg::kind_t              in_kind;
    ple_pkg::cmp_t               pos_c, cnt_c;
    logic                        in_list, ins_ok;
    ple_pkg::addr_t              pos_addr, cnt_addr, pos_next_addr;
    logic                        out_free;

    assign in_pos   = s_tdata[ple_pkg::POS_W-1:0];
    assign in_entry = s_tdata[ple_pkg::POS_W +: ple_pkg::ENTRY_W];
    assign in_kind  = ple_pkg::kind_t'(s_tuser);

    assign pos_c = ple_pkg::CMP_W'(in_pos);
    assign cnt_c = ple_pkg::CMP_W'(count_reg);

    assign in_list = (pos_c != '0) && (pos_c <= cnt_c);
    assign ins_ok  = (pos_c != '0) && (pos_c <= cnt_c + 1'b1)
                     && (cnt_c < ple_pkg::CMP_W'(ple_pkg::CAPACITY));

    assign pos_addr      = ple_pkg::addr_t'(pos_c - 1'b1);
    assign cnt_addr      = ple_pkg::addr_t'(cnt_c - 1'b1);
    assign pos_next_addr = ple_pkg::addr_t'(pos_c);

    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ple_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ra_next       = ra_reg;
        end_next      = end_reg;
        wa_next       = wa_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        up_next       = up_reg;
        fin_addr_next = fin_addr_reg;
        val_next      = val_reg;
        res_ok_next   = res_ok_reg;
        res_data_next = res_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_wa        = wa_reg;
        mem_wd        = rdata_reg;
        mem_re        = 1'b0;
        mem_ra        = ra_reg;

        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_ok_next   = 1'b0;
                    res_data_next = '0;
                    state_next    = ple_pkg::S_DONE;
                    unique case (in_kind)
                        ple_pkg::KIND_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                res_ok_next   = 1'b1;
                                count_next    = count_reg + 1'b1;
                                val_next      = ple_pkg::to_word(in_entry);
                                fin_addr_next = pos_addr;
                                up_next       = 1'b1;
                                if (pos_c <= cnt_c)
                                begin
                                    ra_next    = cnt_addr;
                                    end_next   = pos_addr;
                                    issue_next = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = ple_pkg::S_MOVE;
                                end
                                else
                                begin
                                    state_next = ple_pkg::S_FIN;
                                end
                            end
                        end
                        ple_pkg::KIND_REMOVE:
                        begin
                            if (in_list)
                            begin
                                res_ok_next = 1'b1;
                                count_next  = count_reg - 1'b1;
                                up_next     = 1'b0;
                                if (pos_c < cnt_c)
                                begin
                                    ra_next    = pos_next_addr;
                                    end_next   = cnt_addr;
                                    issue_next = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = ple_pkg::S_MOVE;
                                end
                            end
                        end
                        ple_pkg::KIND_READ:
                        begin
                            if (in_list)
                            begin
                                res_ok_next = 1'b1;
                                mem_re      = 1'b1;
                                mem_ra      = pos_addr;
                                state_next  = ple_pkg::S_RDATA;
                            end
                        end
                        ple_pkg::KIND_REPLACE:
                        begin
                            // RAM is read-first: the old word comes back next cycle
                            if (in_list)
                            begin
                                res_ok_next = 1'b1;
                                mem_re      = 1'b1;
                                mem_ra      = pos_addr;
                                mem_we      = 1'b1;
                                mem_wa      = pos_addr;
                                mem_wd      = ple_pkg::to_word(in_entry);
                                state_next  = ple_pkg::S_RDATA;
                            end
                        end
                        ple_pkg::KIND_CLEAR:
                        begin
                            res_ok_next = 1'b1;
                            count_next  = '0;
                        end
                        ple_pkg::KIND_STATUS:
                        begin
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ple_pkg::S_MOVE:
            begin
                // write back the word fetched last cycle, fetch the next one
                mem_we = pend_reg;
                if (issue_reg)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    wa_next   = up_reg ? ra_reg + 1'b1 : ra_reg - 1'b1;
                    if (ra_reg == end_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        ra_next = up_reg ? ra_reg - 1'b1 : ra_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ple_pkg::S_FIN;
                end
            end

            ple_pkg::S_FIN:
            begin
                mem_we     = up_reg;
                mem_wa     = fin_addr_reg;
                mem_wd     = val_reg;
                state_next = ple_pkg::S_DONE;
            end

            ple_pkg::S_RDATA:
            begin
                res_data_next = rdata_reg;
                state_next    = ple_pkg::S_DONE;
            end

            ple_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ple_pkg::M_TDATA_W'({
                        (count_reg == '0),
                        ple_pkg::to_len(count_reg),
                        ple_pkg::to_out(res_data_reg),
                        res_ok_reg});
                    state_next    = ple_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ple_pkg::S_IDLE;
            count_reg    <= '0;
            issue_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg       <= ra_next;
        end_reg      <= end_next;
        wa_reg       <= wa_next;
        up_reg       <= up_next;
        fin_addr_reg <= fin_addr_next;
        val_reg      <= val_next;
        res_ok_reg   <= res_ok_next;
        res_data_reg <= res_data_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // entry RAM, read-first
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

`include "positional_list_engine_assert.svh"

    `PLE_ASSERT_NOW(a_count_bound, 1'b1,
        count_reg <= ple_pkg::CNT_W'(ple_pkg::CAPACITY), "count above capacity")

    `PLE_ASSERT_NOW(a_move_no_overlap, mem_we && mem_re && (state_reg == ple_pkg::S_MOVE),
        mem_wa != mem_ra, "move reads and writes the same slot")

    `PLE_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready,
        state_reg != ple_pkg::S_IDLE, "command accepted but engine stayed idle")

    `PLE_ASSERT_NEXT(a_result_load, (state_reg == ple_pkg::S_DONE) && out_free,
        m_tvalid_reg && (state_reg == ple_pkg::S_IDLE), "finished result not presented")

endmodule
